[design/co2fs_pkg.sv]
// co2fs_pkg: shared types and constants for the co2 frame sniffer with median filter
// used by co2_frame_sniffer_median; no dependencies
package co2fs_pkg;

    localparam int WIN_DEPTH = 32;
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int ADDR_W    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

    localparam logic [7:0]  START_BYTE = 8'h16;
    localparam logic [3:0]  FRAME_LAST = 4'd8;
    localparam logic [15:0] MIN_RESET  = 16'd350;
    localparam logic [15:0] MAX_RESET  = 16'd5000;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_CHECKSUM  = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_PUBLISHED = 3'd3;
    localparam logic [2:0] ST_NODATA    = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;

    localparam logic REG_MIN = 1'b0;
    localparam logic REG_MAX = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] reading_ppm;
        logic [5:0]  window_count;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_FETCH,
        S_SCAN,
        S_EVAL,
        S_DONE
    } state_t;

endpackage

[design/co2_frame_sniffer_median.sv]
// co2_frame_sniffer_median: uart frame collector, checksum check and median selector
// depends on co2fs_pkg
// a completed frame's result is registered when its checksum byte is taken
// an update runs the rank-count loop, which reads the
// sample window one entry per cycle through its single read port and one shared comparator
// input is stalled while an update runs or a result waits in the output register
// reset clears control state, the sample count and the frame position and loads the limits
// with 350 and 5000; the sample window itself is not cleared
module co2_frame_sniffer_median (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  co2fs_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output co2fs_pkg::out_item_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import co2fs_pkg::*;

    state_t state_reg, state_next;

    logic [15:0]       min_reg, max_reg;
    logic [3:0]        pos_reg, pos_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        hi_reg, hi_next;
    logic [7:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  less_reg, less_next;
    logic [CNT_W-1:0]  equal_reg, equal_next;
    logic [15:0]       cand_reg, cand_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [15:0]       win_mem [WIN_DEPTH];
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [15:0]       wr_data;

    logic              in_xfer, out_free;
    logic [CNT_W-1:0]  rank_k;
    logic [CNT_W:0]    less_eq_sum;
    logic              rank_hit, last_j, last_i;
    logic [7:0]        expect_sum;
    logic [15:0]       frame_ppm;
    logic              in_range;
    logic              cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_MAX) ? {16'd0, max_reg} : {16'd0, min_reg};

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign in_xfer  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign rank_k      = count_reg >> 1;
    assign less_eq_sum = {1'b0, less_reg} + {1'b0, equal_reg};
    assign rank_hit    = (less_reg <= rank_k) && ({1'b0, rank_k} < less_eq_sum);
    assign last_j      = (j_reg == count_reg - 1'b1);
    assign last_i      = (i_reg == count_reg - 1'b1);
    assign expect_sum  = 8'd0 - sum_reg;
    assign frame_ppm   = {hi_reg, in_data.rx_byte};
    assign in_range    = (cand_reg >= min_reg) && (cand_reg <= max_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MIN)
                min_reg <= pwdata[15:0];
            else
                max_reg <= pwdata[15:0];
        end
    end

    // sample window memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            win_mem[count_reg[ADDR_W-1:0]] <= wr_data;
        rd_data_reg <= win_mem[rd_addr];
    end

    always_comb
    begin
        unique case (state_reg)
            S_CAND:  rd_addr = i_reg[ADDR_W-1:0];
            S_SCAN:  rd_addr = ADDR_W'(j_reg + 1'b1);
            default: rd_addr = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_xfer && in_data.opcode == OP_UPDATE && count_reg != '0)
                    state_next = S_CAND;
            S_CAND:  state_next = S_FETCH;
            S_FETCH: state_next = S_SCAN;
            S_SCAN:
                if (last_j)
                    state_next = S_EVAL;
            S_EVAL:
                if (rank_hit || last_i)
                    state_next = S_DONE;
                else
                    state_next = S_CAND;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and result register updates
    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        less_next      = less_reg;
        equal_next     = equal_reg;
        cand_next      = cand_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_data        = frame_ppm;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && in_data.opcode == OP_BYTE)
                begin
                    priority if (pos_reg == 4'd0)
                    begin
                        if (in_data.rx_byte == START_BYTE)
                        begin
                            pos_next = 4'd1;
                            sum_next = 8'd0;
                        end
                    end
                    else if (pos_reg == FRAME_LAST)
                    begin
                        pos_next       = 4'd0;
                        out_valid_next = 1'b1;
                        if (in_data.rx_byte != expect_sum)
                        begin
                            out_data_next.status       = ST_CHECKSUM;
                            out_data_next.reading_ppm  = 16'd0;
                            out_data_next.window_count = 6'(count_reg);
                        end
                        else if (count_reg < CNT_W'(WIN_DEPTH))
                        begin
                            wr_en                      = 1'b1;
                            wr_data                    = {hi_reg, lo_reg};
                            count_next                 = count_reg + 1'b1;
                            out_data_next.status       = ST_ACCEPTED;
                            out_data_next.reading_ppm  = {hi_reg, lo_reg};
                            out_data_next.window_count = 6'(count_reg + 1'b1);
                        end
                        else
                        begin
                            out_data_next.status       = ST_DROPPED;
                            out_data_next.reading_ppm  = {hi_reg, lo_reg};
                            out_data_next.window_count = 6'(count_reg);
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                        sum_next = sum_reg + in_data.rx_byte;
                        if (pos_reg == 4'd3)
                            hi_next = in_data.rx_byte;
                        if (pos_reg == 4'd4)
                            lo_next = in_data.rx_byte;
                    end
                end
                else if (in_xfer && in_data.opcode == OP_UPDATE)
                begin
                    if (count_reg == '0)
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next.status       = ST_NODATA;
                        out_data_next.reading_ppm  = 16'd0;
                        out_data_next.window_count = 6'd0;
                    end
                    else
                        i_next = '0;
                end
            end
            S_CAND: ;
            S_FETCH:
            begin
                cand_next  = rd_data_reg;
                j_next     = '0;
                less_next  = '0;
                equal_next = '0;
            end
            S_SCAN:
            begin
                if (rd_data_reg < cand_reg)
                    less_next = less_reg + 1'b1;
                else if (rd_data_reg == cand_reg)
                    equal_next = equal_reg + 1'b1;
                j_next = j_reg + 1'b1;
            end
            S_EVAL:
            begin
                // no rank match on the final candidate reports zero
                if (!rank_hit)
                begin
                    i_next = i_reg + 1'b1;
                    if (last_i)
                        cand_next = 16'd0;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    count_next                 = '0;
                    out_valid_next             = 1'b1;
                    out_data_next.status       = in_range ? ST_PUBLISHED : ST_RANGE;
                    out_data_next.reading_ppm  = cand_reg;
                    out_data_next.window_count = 6'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= 4'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        less_reg     <= less_next;
        equal_reg    <= equal_next;
        cand_reg     <= cand_next;
        out_data_reg <= out_data_next;
    end

endmodule
